[hw/rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command and status codes and the default depth shared by the deque core.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Default number of entries in the ring.
  localparam int unsigned DefaultDepth = 16;

  // Fixed field widths.
  localparam int unsigned CmdW    = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CmdW-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CmdW-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CmdW-1:0] CMD_SEARCH     = 3'd4;

  // Status codes.
  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

endpackage

[hw/rtl/double_ended_queue_with_search_core.sv]
// ----------------------------------------------------------------------------
// Double-ended queue with search
// A bounded deque of 32-bit values held in a ring buffer memory. Each item
// is a command (push or pop at either end, or search) and yields one result.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o | command_i, value_i
//   out     | output    | out_valid_o / out_stall_i | status_o, found_o, entry_count_o
//
// Pushes and pops load their result into the output register at the edge
// that accepts the item. A search reads the ring memory one entry per cycle
// from the front, as the single read port allows, and ends early on a hit.
// Reset clears the head pointer, the count and all control state; the ring
// memory is not cleared. A stalled output holds its result, and a new item
// is taken only when the output register is free or is emptied in that cycle.
module double_ended_queue_with_search_core #(
  parameter int unsigned DEPTH = deq_pkg::DefaultDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [deq_pkg::CmdW-1:0]          command_i,
  input  logic signed [deq_pkg::DataW-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [deq_pkg::StatusW-1:0]       status_o,
  output logic                              found_o,
  output logic [deq_pkg::CountW-1:0]        entry_count_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);

  // Controller states.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;

  logic [1:0]                    state_q, state_d;
  logic [IdxW-1:0]               head_q, head_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [IdxW-1:0]               rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]               issue_q, issue_d;
  logic                          rd_vld_q, rd_vld_d;
  logic                          hit_q, hit_d;
  logic [deq_pkg::DataW-1:0]     key_q, key_d;
  logic                          out_valid_q, out_valid_d;
  logic [deq_pkg::StatusW-1:0]   status_q, status_d;
  logic                          found_q, found_d;
  logic [CntW-1:0]               out_cnt_q, out_cnt_d;

  // Ring memory and its ports.
  logic [deq_pkg::DataW-1:0]     ring_mem [DEPTH];
  logic [deq_pkg::DataW-1:0]     rd_data_q;
  logic                          wr_en;
  logic [IdxW-1:0]               wr_addr;
  logic                          rd_en;

  logic                          out_free;
  logic                          in_acc;
  logic [SumW-1:0]               back_sum;
  logic [IdxW-1:0]               back_idx;
  logic [IdxW-1:0]               head_dec;
  logic [IdxW-1:0]               head_inc;
  logic                          hit_now;
  logic                          scan_done;
  logic [CntW+deq_pkg::CountW-1:0] cnt_wide;

  // Handshake.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Ring position arithmetic with wrap at DEPTH.
  assign back_sum = {1'b0, head_q} + {1'b0, count_q};
  assign back_idx = (back_sum >= DepthSum) ? IdxW'(back_sum - DepthSum) : IdxW'(back_sum);
  assign head_dec = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;

  // Search compare on the registered read data.
  assign hit_now   = rd_vld_q && (rd_data_q == key_q);
  assign scan_done = hit_q || hit_now || ((issue_q == count_q) && !rd_vld_q);

  // Command decode and search sequencing.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    hit_d       = hit_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    found_d     = found_q;
    out_cnt_d   = out_cnt_q;
    wr_en       = 1'b0;
    wr_addr     = head_q;
    rd_en       = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          out_valid_d = 1'b1;
          status_d    = deq_pkg::ST_DONE;
          found_d     = 1'b0;
          case (command_i)
            deq_pkg::CMD_PUSH_FRONT: begin
              if (count_q == FullCnt) begin
                status_d = deq_pkg::ST_FULL;
              end else begin
                head_d  = head_dec;
                wr_en   = 1'b1;
                wr_addr = head_dec;
                count_d = count_q + 1'b1;
              end
            end
            deq_pkg::CMD_PUSH_BACK: begin
              if (count_q == FullCnt) begin
                status_d = deq_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = back_idx;
                count_d = count_q + 1'b1;
              end
            end
            deq_pkg::CMD_POP_FRONT: begin
              if (count_q == '0) begin
                status_d = deq_pkg::ST_EMPTY;
              end else begin
                head_d  = head_inc;
                count_d = count_q - 1'b1;
              end
            end
            deq_pkg::CMD_POP_BACK: begin
              if (count_q == '0) begin
                status_d = deq_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            deq_pkg::CMD_SEARCH: begin
              // The result is produced when the scan ends.
              out_valid_d = out_valid_q && out_stall_i;
              state_d     = StScan;
              rd_ptr_d    = head_q;
              issue_d     = '0;
              hit_d       = 1'b0;
              key_d       = value_i;
            end
            default: begin
            end
          endcase
          out_cnt_d = count_d;
        end
      end
      StScan: begin
        hit_d = hit_q || hit_now;
        if (scan_done) begin
          // Hold the verdict until the output register is free.
          if (out_free) begin
            out_valid_d = 1'b1;
            status_d    = deq_pkg::ST_DONE;
            found_d     = hit_q || hit_now;
            out_cnt_d   = count_q;
            state_d     = StIdle;
          end
        end else if (issue_q != count_q) begin
          // Issue the next read from the front toward the back.
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          issue_d  = issue_q + 1'b1;
          rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    status_q  <= status_d;
    found_q   <= found_d;
    out_cnt_q <= out_cnt_d;
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= value_i;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_ptr_q];
    end
  end

  // Outputs; the count is reported in five bits.
  assign cnt_wide      = {{deq_pkg::CountW{1'b0}}, out_cnt_q};
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign entry_count_o = cnt_wide[deq_pkg::CountW-1:0];

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Double-ended queue with search testbench
// Drives push, pop, search and unused commands into the deque core under
// random gaps and output stalls. A scoreboard keeps its own ring model and
// compares every result in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int unsigned Depth      = DefaultDepth;
  localparam int unsigned RandItems  = 950;
  localparam int unsigned IdlePct    = 9;
  localparam int unsigned QuietFrom  = 200;
  localparam int unsigned QuietTo    = 900;
  localparam int unsigned HoldAfter  = 400;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned DrainWait  = Depth + 8;
  localparam logic [CmdW-1:0] CmdMax = '1;
  localparam logic signed [DataW-1:0] ValMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] ValMax = {1'b0, {(DataW-1){1'b1}}};

  typedef struct packed {
    logic [CmdW-1:0]         cmd;
    logic signed [DataW-1:0] val;
  } deq_cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               found;
    logic [CountW-1:0]  count;
  } deq_result_t;

  // Ring model of the deque and the queue of results it still owes.
  class deq_scoreboard;
    logic signed [DataW-1:0] ring[Depth];
    int unsigned head;
    int unsigned held;
    deq_result_t owed_q[$];
    int unsigned errors;

    function new();
      head   = 0;
      held   = 0;
      errors = 0;
    endfunction

    task report(string what);
      errors++;
      $display("tb: mismatch at %0t: %s", $time, what);
    endtask

    // Apply one accepted command to the model and queue its result.
    function void note_command(logic [CmdW-1:0] cmd, logic signed [DataW-1:0] val);
      deq_result_t r;
      r.status = ST_DONE;
      r.found  = 1'b0;
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (held >= Depth) begin
            r.status = ST_FULL;
          end else begin
            head       = (head + Depth - 1) % Depth;
            ring[head] = val;
            held++;
          end
        end
        CMD_PUSH_BACK: begin
          if (held >= Depth) begin
            r.status = ST_FULL;
          end else begin
            ring[(head + held) % Depth] = val;
            held++;
          end
        end
        CMD_POP_FRONT: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            head = (head + 1) % Depth;
            held--;
          end
        end
        CMD_POP_BACK: begin
          if (held == 0) r.status = ST_EMPTY;
          else held--;
        end
        CMD_SEARCH: begin
          for (int unsigned i = 0; i < held; i++) begin
            if (ring[(head + i) % Depth] == val) r.found = 1'b1;
          end
        end
        default: ;
      endcase
      r.count = CountW'(held);
      owed_q.push_back(r);
    endfunction

    // Compare one accepted result with the oldest owed one.
    task check_result(deq_result_t got);
      deq_result_t exp;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d found=%0d count=%0d",
                         got.status, got.found, got.count));
      end else begin
        exp = owed_q.pop_front();
        if (got.status !== exp.status)
          report($sformatf("status %0d, want %0d", got.status, exp.status));
        if (got.found !== exp.found)
          report($sformatf("found %0d, want %0d", got.found, exp.found));
        if (got.count !== exp.count)
          report($sformatf("entry_count %0d, want %0d", got.count, exp.count));
      end
    endtask

    function int unsigned owed();
      return owed_q.size();
    endfunction
  endclass

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [CmdW-1:0]         command_i    = '0;
  logic signed [DataW-1:0] value_i      = '0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic [StatusW-1:0]      status_o;
  logic                    found_o;
  logic [CountW-1:0]       entry_count_o;

  deq_scoreboard           sb;
  deq_cmd_t                stim_q[$];
  logic signed [DataW-1:0] recent_q[$];
  int unsigned             cyc          = 0;
  int unsigned             accepted_n   = 0;
  int unsigned             hold_left    = 0;
  bit                      hold_done    = 1'b0;

  double_ended_queue_with_search_core #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .entry_count_o (entry_count_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  function automatic bit quiet_window();
    return (cyc >= QuietFrom) && (cyc < QuietTo);
  endfunction

  function automatic void add_cmd(logic [CmdW-1:0] cmd, logic signed [DataW-1:0] val);
    deq_cmd_t c;
    c.cmd = cmd;
    c.val = val;
    stim_q.push_back(c);
    if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
      recent_q.push_back(val);
      if (recent_q.size() > 24) void'(recent_q.pop_front());
    end
  endfunction

  // Small values collide often, so searches hit and miss in good measure.
  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return $signed(DataW'($urandom_range(0, 7))) - 3;
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       return ValMin;
        1:       return ValMax;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [DataW-1:0] pick_search();
    if (recent_q.size() > 0 && $urandom_range(0, 1) == 1)
      return recent_q[$urandom_range(0, recent_q.size() - 1)];
    return pick_value();
  endfunction

  // Edge cases: empty pops and search, unused codes, filling to full.
  task automatic build_directed();
    add_cmd(CMD_SEARCH, ValMax);
    add_cmd(CMD_POP_FRONT, $urandom);
    add_cmd(CMD_POP_BACK, $urandom);
    for (int c = CMD_SEARCH + 1; c <= CmdMax; c++) add_cmd(CmdW'(c), $urandom);
    add_cmd(CMD_PUSH_FRONT, ValMin);
    add_cmd(CMD_PUSH_BACK, ValMax);
    for (int i = 2; i < Depth; i++) begin
      if (i % 2 == 0) add_cmd(CMD_PUSH_FRONT, i);
      else add_cmd(CMD_PUSH_BACK, -i);
    end
    add_cmd(CMD_PUSH_BACK, 32'sd77);
    add_cmd(CMD_PUSH_FRONT, 32'sd78);
    add_cmd(CMD_SEARCH, ValMax);
    add_cmd(CMD_SEARCH, ValMin);
    add_cmd(CMD_SEARCH, 32'sd77);
    add_cmd(CMD_POP_FRONT, $urandom);
    add_cmd(CMD_POP_BACK, $urandom);
  endtask

  // Bursts that lean toward filling, draining, mixing or searching.
  task automatic build_random(int unsigned n);
    int unsigned made;
    int unsigned mode;
    int unsigned burst;
    int unsigned r;
    made = 0;
    while (made < n) begin
      mode  = $urandom_range(0, 3);
      burst = $urandom_range(8, 30);
      for (int unsigned k = 0; k < burst && made < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          add_cmd(CmdW'($urandom_range(CMD_SEARCH + 1, CmdMax)), $urandom);
          continue;
        end
        r = $urandom_range(0, 99);
        case (mode)
          0:       r = (r < 75) ? 0 : (r < 85) ? 1 : 2;
          1:       r = (r < 15) ? 0 : (r < 85) ? 1 : 2;
          2:       r = (r < 40) ? 0 : (r < 75) ? 1 : 2;
          default: r = (r < 30) ? 0 : (r < 45) ? 1 : 2;
        endcase
        case (r)
          0: add_cmd($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
          1: add_cmd($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, $urandom);
          default: add_cmd(CMD_SEARCH, pick_search());
        endcase
        made++;
      end
    end
  endtask

  // Offer every queued item; valid is only decided once the current item is taken.
  task automatic send_items();
    int unsigned idx;
    bit          offered;
    idx     = 0;
    offered = 1'b0;
    while (idx < stim_q.size() || offered) begin
      @(posedge clk_i);
      if (offered && !in_stall_o) begin
        sb.note_command(command_i, value_i);
        accepted_n++;
        offered = 1'b0;
      end
      if (!offered) begin
        if (idx < stim_q.size() &&
            (quiet_window() || $urandom_range(0, 99) >= IdlePct)) begin
          command_i  <= stim_q[idx].cmd;
          value_i    <= stim_q[idx].val;
          in_valid_i <= 1'b1;
          offered    = 1'b1;
          idx++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
    @(posedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Result side: check taken results, then choose the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{status: status_o, found: found_o, count: entry_count_o});
    end
    if (!hold_done && accepted_n >= HoldAfter) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= (hold_left > 1);
    end else if (quiet_window()) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < IdlePct);
    end
  end

  initial begin
    sb = new();
    build_directed();
    build_random(RandItems);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_items();
    while (sb.owed() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

[files.f]
hw/rtl/deq_pkg.sv
hw/rtl/double_ended_queue_with_search_core.sv
bench/tb.sv
